// ===== hw/rtl/hhfm_pkg.sv =====
// ============================================================================
// hhfm_pkg
// Shared types, codes and default sizes for the humidity heater fault monitor.
// ============================================================================
package hhfm_pkg;

    // Default sizes of the stores and windows
    localparam int HISTORY_DEPTH_DEF = 16;
    localparam int STUCK_SAMPLES_DEF = 8;
    localparam int MAX_PULSES_DEF    = 4;
    localparam int FAULT_BUCKETS_DEF = 2;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int RH_W       = 14;
    localparam int TEMP_W     = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register reset values
    localparam logic [TIME_W-1:0] INTERVAL_RST = 32'd2000;
    localparam logic [TIME_W-1:0] PULSE_RST    = 32'd1000;
    localparam logic [TIME_W-1:0] COOLDOWN_RST = 32'd10000;
    localparam logic [RH_W-1:0]   RH_THR_RST   = 14'd9500;
    localparam logic [TEMP_W-1:0] SPREAD_RST   = 15'd20;
    localparam logic [TIME_W-1:0] WINDOW_RST   = 32'd3600000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENSOR_PRESENT = 3'd0,
        REG_SAMPLE_INTERVAL = 3'd1,
        REG_HEATER_PULSE   = 3'd2,
        REG_COOLDOWN       = 3'd3,
        REG_RH_THRESHOLD   = 3'd4,
        REG_TEMP_SPREAD    = 3'd5,
        REG_PULSE_WINDOW   = 3'd6
    } cfg_reg_t;

    // One entry of the sample history
    typedef struct packed {
        logic                     valid;
        logic                     heated;
        logic                     settling;
        logic signed [TEMP_W-1:0] temp;
        logic [RH_W-1:0]          rh;
    } sample_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAT,
        ST_SCAN,
        ST_JUDGE,
        ST_PRE,
        ST_FIRE,
        ST_EVENT,
        ST_DIV,
        ST_BUCK,
        ST_FAULT,
        ST_COUNT,
        ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/hhfm_ram.sv =====
// ============================================================================
// hhfm_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module hhfm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/hhfm_div.sv =====
// ============================================================================
// hhfm_div
// Bit-serial 32-bit divider for the bucket advance. Gives the remainder, the
// quotient saturated at the bucket count and the quotient modulo that count.
// ============================================================================
module hhfm_div #(
    parameter int FAULT_BUCKETS = hhfm_pkg::FAULT_BUCKETS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [hhfm_pkg::TIME_W-1:0]      dividend,
    input  logic [hhfm_pkg::TIME_W-1:0]      divisor,
    output logic                             done,
    output logic [hhfm_pkg::TIME_W-1:0]      rem,
    output logic [$clog2(FAULT_BUCKETS+1)-1:0] q_sat,
    output logic [$clog2(FAULT_BUCKETS)-1:0]   q_mod
);

    localparam int TW = hhfm_pkg::TIME_W;
    localparam int QW = $clog2(FAULT_BUCKETS+1);
    localparam int MW = $clog2(FAULT_BUCKETS);
    localparam int BW = $clog2(TW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [BW-1:0] bit_reg, bit_next;
    logic [TW-1:0] dvd_reg, dvd_next;
    logic [TW-1:0] rem_reg, rem_next;
    logic [QW-1:0] qs_reg, qs_next;
    logic [MW-1:0] qm_reg, qm_next;

    logic [TW:0]   shifted;
    logic          qbit;
    logic [QW:0]   qs_dbl;
    logic [MW:0]   qm_dbl;

    // One quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        bit_next  = bit_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        qs_next   = qs_reg;
        qm_next   = qm_reg;
        shifted   = {rem_reg, dvd_reg[TW-1]};
        qbit      = (shifted >= {1'b0, divisor});
        qs_dbl    = {qs_reg, qbit};
        qm_dbl    = {qm_reg, qbit};
        if (start)
        begin
            busy_next = 1'b1;
            bit_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            qs_next   = '0;
            qm_next   = '0;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? TW'(shifted - {1'b0, divisor}) : TW'(shifted);
            dvd_next = {dvd_reg[TW-2:0], 1'b0};
            qs_next  = (qs_dbl >= (QW+1)'(FAULT_BUCKETS)) ? QW'(FAULT_BUCKETS) : QW'(qs_dbl);
            qm_next  = (qm_dbl >= (MW+1)'(FAULT_BUCKETS)) ?
                       MW'(qm_dbl - (MW+1)'(FAULT_BUCKETS)) : MW'(qm_dbl);
            bit_next = bit_reg + 1'b1;
            if (bit_reg == BW'(TW-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        qs_reg  <= qs_next;
        qm_reg  <= qm_next;
    end

    assign done  = done_reg;
    assign rem   = rem_reg;
    assign q_sat = qs_reg;
    assign q_mod = qm_reg;

endmodule

// ===== hw/rtl/humidity_heater_fault_monitor.sv =====
// ============================================================================
// humidity_heater_fault_monitor
// Wet-stuck detection on a humidity sensor, rate-limited heater pulses,
// hourly condensation fault and before/after pulse records.
// ============================================================================
// Usage:
//  Input channel (in_valid / in_stall) carries one item: time stamp and one
//  reading. Output channel (out_valid / out_stall) returns exactly one result
//  per item, in order. Configuration is a plain write port (cfg_we,
//  cfg_index, cfg_data), to be written only while the block is idle; the
//  block itself does not enforce this. A sample item can run the history
//  scan (one read per cycle) and the bucket advance divider; a skipped item
//  or one with the sensor absent runs neither. One item at a time.
//  The sample history lives in a RAM with a registered read port; the scan
//  reads it back after the new entry is written.
//  Reset clears all control state and loads the register defaults; no
//  clearing pass is needed.
//  The result sits in an output register: a new item is taken while it
//  waits, and the sequencer holds its last step while that result is stalled.
// ============================================================================
module humidity_heater_fault_monitor #(
    parameter int HISTORY_DEPTH = hhfm_pkg::HISTORY_DEPTH_DEF,
    parameter int STUCK_SAMPLES = hhfm_pkg::STUCK_SAMPLES_DEF,
    parameter int MAX_PULSES    = hhfm_pkg::MAX_PULSES_DEF,
    parameter int FAULT_BUCKETS = hhfm_pkg::FAULT_BUCKETS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [hhfm_pkg::TIME_W-1:0]         time_ms,
    input  logic                                reading_valid,
    input  logic signed [hhfm_pkg::TEMP_W-1:0]  temperature_centi,
    input  logic [hhfm_pkg::RH_W-1:0]           humidity_centi,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                sample_taken,
    output logic                                heater_on,
    output logic                                wet_stuck,
    output logic [2:0]                          pulses_in_window,
    output logic                                condensation_fault,
    output logic                                event_done,
    output logic [hhfm_pkg::TIME_W-1:0]         event_duration_ms,
    output logic [hhfm_pkg::RH_W-1:0]           event_rh_before,
    output logic signed [hhfm_pkg::TEMP_W-1:0]  event_temp_before,
    output logic                                event_after_valid,
    output logic [hhfm_pkg::RH_W-1:0]           event_rh_after,
    output logic signed [hhfm_pkg::TEMP_W-1:0]  event_temp_after,
    input  logic                                cfg_we,
    input  logic [hhfm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hhfm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int TW  = hhfm_pkg::TIME_W;
    localparam int RW  = hhfm_pkg::RH_W;
    localparam int TPW = hhfm_pkg::TEMP_W;
    localparam int SW  = $bits(hhfm_pkg::sample_t);
    localparam int HAW = $clog2(HISTORY_DEPTH);
    localparam int HFW = $clog2(HISTORY_DEPTH+1);
    localparam int PW  = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;
    localparam int PFW = $clog2(MAX_PULSES+1);
    localparam int BW  = $clog2(FAULT_BUCKETS);
    localparam int QW  = $clog2(FAULT_BUCKETS+1);
    localparam int SCN = (STUCK_SAMPLES > MAX_PULSES) ? STUCK_SAMPLES : MAX_PULSES;
    localparam int CW  = $clog2(SCN+1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    hhfm_pkg::state_t state_reg, state_next;

    logic          present_reg, present_next;
    logic [TW-1:0] interval_reg, interval_next;
    logic [TW-1:0] pulse_ms_reg, pulse_ms_next;
    logic [TW-1:0] cooldown_reg, cooldown_next;
    logic [RW-1:0] thr_reg, thr_next;
    logic [TPW-1:0] spread_reg, spread_next;
    logic [TW-1:0] window_reg, window_next;

    logic [TW-1:0]         now_reg, now_next;
    logic                  rvalid_reg, rvalid_next;
    logic signed [TPW-1:0] temp_reg, temp_next;
    logic [RW-1:0]         rh_reg, rh_next;

    logic [HAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [HFW-1:0] hfill_reg, hfill_next;
    logic [TW-1:0]  last_sample_reg, last_sample_next;
    logic [HAW-1:0] rd_ptr_reg, rd_ptr_next;

    logic          heater_reg, heater_next;
    logic [TW-1:0] heat_start_reg, heat_start_next;
    logic [TW-1:0] settle_reg, settle_next;
    logic [TW-1:0] last_pulse_reg, last_pulse_next;
    logic [TW-1:0] ring_reg [MAX_PULSES];
    logic [TW-1:0] ring_next [MAX_PULSES];
    logic [PW-1:0] ring_ptr_reg, ring_ptr_next;
    logic [PFW-1:0] ring_fill_reg, ring_fill_next;

    logic [15:0]   counts_reg [FAULT_BUCKETS];
    logic [15:0]   counts_next [FAULT_BUCKETS];
    logic [BW-1:0] bidx_reg, bidx_next;
    logic [TW-1:0] bstart_reg, bstart_next;
    logic [QW-1:0] bfill_reg, bfill_next;
    logic          fault_reg, fault_next;
    logic          stuck_reg, stuck_next;

    logic                  pending_reg, pending_next;
    logic                  awaiting_reg, awaiting_next;
    logic [TW-1:0]         pdur_reg, pdur_next;
    logic [RW-1:0]         prh_reg, prh_next;
    logic signed [TPW-1:0] ptemp_reg, ptemp_next;

    logic                  ok_reg, ok_next;
    logic signed [TPW-1:0] mn_reg, mn_next;
    logic signed [TPW-1:0] mx_reg, mx_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [PFW-1:0]        acc_reg, acc_next;

    logic taken_reg, taken_next;
    logic fired_reg, fired_next;
    logic adv_reg, adv_next;

    logic                  evd_reg, evd_next;
    logic [TW-1:0]         evdur_reg, evdur_next;
    logic [RW-1:0]         evrhb_reg, evrhb_next;
    logic signed [TPW-1:0] evtb_reg, evtb_next;
    logic                  evav_reg, evav_next;
    logic [RW-1:0]         evrha_reg, evrha_next;
    logic signed [TPW-1:0] evta_reg, evta_next;

    logic out_valid_reg, out_valid_next;
    logic o_taken_reg, o_heater_reg, o_stuck_reg, o_fault_reg;
    logic [2:0] o_count_reg;
    logic o_done_reg, o_av_reg;
    logic [TW-1:0] o_dur_reg;
    logic [RW-1:0] o_rhb_reg, o_rha_reg;
    logic signed [TPW-1:0] o_tb_reg, o_ta_reg;

    // ------------------------------------------------------------------
    // Helper signals
    // ------------------------------------------------------------------
    logic          in_xfer;
    logic          load_out;
    logic [TW-1:0] w_eff;
    logic          heat_off;
    logic          heat_now;
    logic [TW-1:0] settle_eff;
    logic          skip;
    logic [HFW-1:0] hfill_inc;
    hhfm_pkg::sample_t new_sample;
    hhfm_pkg::sample_t rd_sample;
    logic [SW-1:0] ram_rdata;
    logic          ram_we;
    logic          entry_ok;
    logic signed [TPW:0] spread_val;
    logic          ring_hit;
    logic [PFW-1:0] acc_inc;
    logic          pre_ok;
    logic          div_start;
    logic          div_done;
    logic [TW-1:0] div_rem;
    logic [QW-1:0] div_qs;
    logic [BW-1:0] div_qm;
    logic [QW-1:0] k_sat;
    logic [BW-1:0] k_mod;
    logic [BW:0]   idx_sum;
    logic [BW-1:0] new_idx;
    logic [BW:0]   bdist;
    logic          clr;
    logic [15:0]   base;
    logic [QW:0]   fill_sum;
    logic [BW-1:0] prev_idx;
    logic [PFW+2:0] acc_wide;

    assign in_xfer  = in_valid && !in_stall;
    assign in_stall = (state_reg != hhfm_pkg::ST_IDLE);
    assign load_out = (state_reg == hhfm_pkg::ST_OUT) && (!out_valid_reg || !out_stall);
    assign w_eff    = (window_reg == '0) ? TW'(1) : window_reg;

    // Heater turn-off and pacing at the head of an item
    assign heat_off   = heater_reg && ((now_reg - heat_start_reg) >= pulse_ms_reg);
    assign heat_now   = heater_reg && !heat_off;
    assign settle_eff = heat_off ? (now_reg + cooldown_reg) : settle_reg;
    assign skip       = (last_sample_reg != '0) && ((now_reg - last_sample_reg) < interval_reg);
    assign hfill_inc  = (32'(hfill_reg) < 32'(HISTORY_DEPTH)) ? hfill_reg + 1'b1 : hfill_reg;

    always_comb
    begin
        new_sample.valid    = rvalid_reg;
        new_sample.heated   = heat_now;
        new_sample.settling = !heat_now && (settle_eff != '0) && (now_reg < settle_eff);
        new_sample.temp     = temp_reg;
        new_sample.rh       = rh_reg;
    end

    assign ram_we = (state_reg == hhfm_pkg::ST_HEAT) && present_reg && !skip;

    hhfm_ram #(
        .WIDTH (SW),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (new_sample),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign rd_sample  = hhfm_pkg::sample_t'(ram_rdata);
    assign entry_ok   = rd_sample.valid && !rd_sample.heated && !rd_sample.settling &&
                        (rd_sample.rh >= thr_reg);
    assign spread_val = (TPW+1)'(mx_reg) - (TPW+1)'(mn_reg);

    // Pulse ring scan step
    assign ring_hit = (cnt_reg < CW'(ring_fill_reg)) &&
                      ((now_reg - ring_reg[cnt_reg[PW-1:0]]) <= w_eff);
    assign acc_inc  = acc_reg + PFW'(ring_hit);
    assign pre_ok   = !heater_reg &&
                      !((settle_reg != '0) && (now_reg < settle_reg)) &&
                      !((last_pulse_reg != '0) && ((now_reg - last_pulse_reg) < interval_reg));

    // Bucket advance divider
    assign div_start = (state_reg == hhfm_pkg::ST_EVENT) && (bstart_reg != '0);

    hhfm_div #(
        .FAULT_BUCKETS (FAULT_BUCKETS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (now_reg - bstart_reg),
        .divisor  (w_eff),
        .done     (div_done),
        .rem      (div_rem),
        .q_sat    (div_qs),
        .q_mod    (div_qm)
    );

    assign k_sat    = adv_reg ? div_qs : '0;
    assign k_mod    = adv_reg ? div_qm : '0;
    assign idx_sum  = (BW+1)'(bidx_reg) + (BW+1)'(k_mod);
    assign new_idx  = (idx_sum >= (BW+1)'(FAULT_BUCKETS)) ?
                      BW'(idx_sum - (BW+1)'(FAULT_BUCKETS)) : BW'(idx_sum);
    assign fill_sum = (QW+1)'(bfill_reg) + (QW+1)'(k_sat);
    assign prev_idx = (bidx_reg == '0) ? BW'(FAULT_BUCKETS-1) : bidx_reg - 1'b1;
    assign acc_wide = {3'b000, acc_reg};

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath updates
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        present_next     = present_reg;
        interval_next    = interval_reg;
        pulse_ms_next    = pulse_ms_reg;
        cooldown_next    = cooldown_reg;
        thr_next         = thr_reg;
        spread_next      = spread_reg;
        window_next      = window_reg;
        now_next         = now_reg;
        rvalid_next      = rvalid_reg;
        temp_next        = temp_reg;
        rh_next          = rh_reg;
        wr_ptr_next      = wr_ptr_reg;
        hfill_next       = hfill_reg;
        last_sample_next = last_sample_reg;
        rd_ptr_next      = rd_ptr_reg;
        heater_next      = heater_reg;
        heat_start_next  = heat_start_reg;
        settle_next      = settle_reg;
        last_pulse_next  = last_pulse_reg;
        ring_next        = ring_reg;
        ring_ptr_next    = ring_ptr_reg;
        ring_fill_next   = ring_fill_reg;
        counts_next      = counts_reg;
        bidx_next        = bidx_reg;
        bstart_next      = bstart_reg;
        bfill_next       = bfill_reg;
        fault_next       = fault_reg;
        stuck_next       = stuck_reg;
        pending_next     = pending_reg;
        awaiting_next    = awaiting_reg;
        pdur_next        = pdur_reg;
        prh_next         = prh_reg;
        ptemp_next       = ptemp_reg;
        ok_next          = ok_reg;
        mn_next          = mn_reg;
        mx_next          = mx_reg;
        cnt_next         = cnt_reg;
        acc_next         = acc_reg;
        taken_next       = taken_reg;
        fired_next       = fired_reg;
        adv_next         = adv_reg;
        evd_next         = evd_reg;
        evdur_next       = evdur_reg;
        evrhb_next       = evrhb_reg;
        evtb_next        = evtb_reg;
        evav_next        = evav_reg;
        evrha_next       = evrha_reg;
        evta_next        = evta_reg;
        out_valid_next   = out_valid_reg;
        bdist            = '0;
        clr              = 1'b0;
        base             = '0;

        // Drop the result once the receiver takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Register writes
        if (cfg_we)
        begin
            case (hhfm_pkg::cfg_reg_t'(cfg_index))
                hhfm_pkg::REG_SENSOR_PRESENT:  present_next  = cfg_data[0];
                hhfm_pkg::REG_SAMPLE_INTERVAL: interval_next = cfg_data;
                hhfm_pkg::REG_HEATER_PULSE:    pulse_ms_next = cfg_data;
                hhfm_pkg::REG_COOLDOWN:        cooldown_next = cfg_data;
                hhfm_pkg::REG_RH_THRESHOLD:    thr_next      = cfg_data[RW-1:0];
                hhfm_pkg::REG_TEMP_SPREAD:     spread_next   = cfg_data[TPW-1:0];
                hhfm_pkg::REG_PULSE_WINDOW:    window_next   = cfg_data;
                default:                       ;
            endcase
        end

        case (state_reg)
            hhfm_pkg::ST_IDLE:
            begin
                // Capture the item and clear the per-item record
                if (in_xfer)
                begin
                    now_next    = time_ms;
                    rvalid_next = reading_valid;
                    temp_next   = temperature_centi;
                    rh_next     = humidity_centi;
                    taken_next  = 1'b0;
                    fired_next  = 1'b0;
                    adv_next    = 1'b0;
                    evd_next    = 1'b0;
                    evdur_next  = '0;
                    evrhb_next  = '0;
                    evtb_next   = '0;
                    evav_next   = 1'b0;
                    evrha_next  = '0;
                    evta_next   = '0;
                    state_next  = hhfm_pkg::ST_HEAT;
                end
            end

            hhfm_pkg::ST_HEAT:
            begin
                cnt_next   = '0;
                acc_next   = '0;
                state_next = hhfm_pkg::ST_COUNT;
                if (present_reg)
                begin
                    // Turn the heater off when its pulse has run out
                    if (heat_off)
                    begin
                        heater_next = 1'b0;
                        settle_next = settle_eff;
                        if (pending_reg)
                        begin
                            pdur_next     = now_reg - heat_start_reg;
                            awaiting_next = 1'b1;
                            pending_next  = 1'b0;
                        end
                    end
                    // Take a sample unless paced out
                    if (!skip)
                    begin
                        taken_next       = 1'b1;
                        last_sample_next = now_reg;
                        wr_ptr_next      = (wr_ptr_reg == HAW'(HISTORY_DEPTH-1)) ?
                                           '0 : wr_ptr_reg + 1'b1;
                        hfill_next       = hfill_inc;
                        stuck_next       = 1'b0;
                        rd_ptr_next      = wr_ptr_reg;
                        ok_next          = 1'b1;
                        if (32'(hfill_inc) >= 32'(STUCK_SAMPLES))
                        begin
                            state_next = hhfm_pkg::ST_SCAN;
                        end
                        else
                        begin
                            state_next = hhfm_pkg::ST_EVENT;
                        end
                    end
                end
            end

            hhfm_pkg::ST_SCAN:
            begin
                // Fold in the entry read last cycle
                if (cnt_reg != '0)
                begin
                    ok_next = ok_reg && entry_ok;
                    if (cnt_reg == CW'(1))
                    begin
                        mn_next = rd_sample.temp;
                        mx_next = rd_sample.temp;
                    end
                    else
                    begin
                        if (rd_sample.temp < mn_reg)
                        begin
                            mn_next = rd_sample.temp;
                        end
                        if (rd_sample.temp > mx_reg)
                        begin
                            mx_next = rd_sample.temp;
                        end
                    end
                end
                // Issue the next read, newest first
                if (cnt_reg < CW'(STUCK_SAMPLES))
                begin
                    rd_ptr_next = (rd_ptr_reg == '0) ? HAW'(HISTORY_DEPTH-1) : rd_ptr_reg - 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = hhfm_pkg::ST_JUDGE;
                end
            end

            hhfm_pkg::ST_JUDGE:
            begin
                cnt_next   = '0;
                acc_next   = '0;
                stuck_next = ok_reg && ({1'b0, spread_val[TPW-1:0]} <= {1'b0, spread_reg});
                if (ok_reg && ({1'b0, spread_val[TPW-1:0]} <= {1'b0, spread_reg}) && pre_ok)
                begin
                    state_next = hhfm_pkg::ST_PRE;
                end
                else
                begin
                    state_next = hhfm_pkg::ST_EVENT;
                end
            end

            hhfm_pkg::ST_PRE:
            begin
                // Count ring entries inside the window before firing
                acc_next = acc_inc;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(MAX_PULSES-1))
                begin
                    if (32'(acc_inc) < 32'(MAX_PULSES))
                    begin
                        state_next = hhfm_pkg::ST_FIRE;
                    end
                    else
                    begin
                        state_next = hhfm_pkg::ST_EVENT;
                    end
                end
            end

            hhfm_pkg::ST_FIRE:
            begin
                // Start a heater pulse
                fired_next      = 1'b1;
                pending_next    = 1'b1;
                awaiting_next   = 1'b0;
                prh_next        = rh_reg;
                ptemp_next      = temp_reg;
                heater_next     = 1'b1;
                heat_start_next = now_reg;
                last_pulse_next = now_reg;
                ring_next[ring_ptr_reg] = now_reg;
                ring_ptr_next   = (ring_ptr_reg == PW'(MAX_PULSES-1)) ? '0 : ring_ptr_reg + 1'b1;
                if (32'(ring_fill_reg) < 32'(MAX_PULSES))
                begin
                    ring_fill_next = ring_fill_reg + 1'b1;
                end
                if (bstart_reg == '0)
                begin
                    bstart_next = now_reg;
                    if (bfill_reg == '0)
                    begin
                        bfill_next = QW'(1);
                    end
                end
                state_next = hhfm_pkg::ST_EVENT;
            end

            hhfm_pkg::ST_EVENT:
            begin
                // Emit the record of a finished pulse
                if (awaiting_reg)
                begin
                    evd_next      = 1'b1;
                    evdur_next    = pdur_reg;
                    evrhb_next    = prh_reg;
                    evtb_next     = ptemp_reg;
                    awaiting_next = 1'b0;
                    if (rvalid_reg)
                    begin
                        evav_next  = 1'b1;
                        evrha_next = rh_reg;
                        evta_next  = temp_reg;
                    end
                end
                if (bstart_reg != '0)
                begin
                    adv_next   = 1'b1;
                    state_next = hhfm_pkg::ST_DIV;
                end
                else if (fired_reg)
                begin
                    state_next = hhfm_pkg::ST_BUCK;
                end
                else
                begin
                    cnt_next   = '0;
                    acc_next   = '0;
                    state_next = hhfm_pkg::ST_COUNT;
                end
            end

            hhfm_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = hhfm_pkg::ST_BUCK;
                end
            end

            hhfm_pkg::ST_BUCK:
            begin
                // Advance buckets and count the new pulse, if one fired
                if (k_sat != '0)
                begin
                    bstart_next = now_reg - div_rem;
                    bidx_next   = new_idx;
                    bfill_next  = (fill_sum >= (QW+1)'(FAULT_BUCKETS)) ?
                                  QW'(FAULT_BUCKETS) : QW'(fill_sum);
                end
                for (int j = 0; j < FAULT_BUCKETS; j++)
                begin
                    bdist = (BW+1)'(j) + (BW+1)'(FAULT_BUCKETS) - (BW+1)'(bidx_reg);
                    if (bdist >= (BW+1)'(FAULT_BUCKETS))
                    begin
                        bdist = bdist - (BW+1)'(FAULT_BUCKETS);
                    end
                    clr  = (k_sat >= QW'(FAULT_BUCKETS)) ||
                           ((bdist != '0) && ((QW+BW+1)'(bdist) <= (QW+BW+1)'(k_sat)));
                    base = clr ? 16'd0 : counts_reg[j];
                    if (fired_reg && (BW'(j) == new_idx) && (base != 16'hFFFF))
                    begin
                        base = base + 16'd1;
                    end
                    counts_next[j] = base;
                end
                state_next = hhfm_pkg::ST_FAULT;
            end

            hhfm_pkg::ST_FAULT:
            begin
                // Latch the fault on two busy buckets in a row
                if (adv_reg && (bfill_reg >= QW'(FAULT_BUCKETS)) &&
                    (32'(counts_reg[bidx_reg]) > 32'(MAX_PULSES)) &&
                    (32'(counts_reg[prev_idx]) > 32'(MAX_PULSES)))
                begin
                    fault_next = 1'b1;
                end
                cnt_next   = '0;
                acc_next   = '0;
                state_next = hhfm_pkg::ST_COUNT;
            end

            hhfm_pkg::ST_COUNT:
            begin
                // Count ring entries for the result
                acc_next = acc_inc;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(MAX_PULSES-1))
                begin
                    state_next = hhfm_pkg::ST_OUT;
                end
            end

            hhfm_pkg::ST_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = hhfm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = hhfm_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control state with reset
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= hhfm_pkg::ST_IDLE;
            present_reg     <= 1'b0;
            interval_reg    <= hhfm_pkg::INTERVAL_RST;
            pulse_ms_reg    <= hhfm_pkg::PULSE_RST;
            cooldown_reg    <= hhfm_pkg::COOLDOWN_RST;
            thr_reg         <= hhfm_pkg::RH_THR_RST;
            spread_reg      <= hhfm_pkg::SPREAD_RST;
            window_reg      <= hhfm_pkg::WINDOW_RST;
            wr_ptr_reg      <= '0;
            hfill_reg       <= '0;
            last_sample_reg <= '0;
            heater_reg      <= 1'b0;
            heat_start_reg  <= '0;
            settle_reg      <= '0;
            last_pulse_reg  <= '0;
            ring_ptr_reg    <= '0;
            ring_fill_reg   <= '0;
            for (int j = 0; j < FAULT_BUCKETS; j++)
            begin
                counts_reg[j] <= '0;
            end
            bidx_reg        <= '0;
            bstart_reg      <= '0;
            bfill_reg       <= '0;
            fault_reg       <= 1'b0;
            stuck_reg       <= 1'b0;
            pending_reg     <= 1'b0;
            awaiting_reg    <= 1'b0;
            pdur_reg        <= '0;
            prh_reg         <= '0;
            ptemp_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            present_reg     <= present_next;
            interval_reg    <= interval_next;
            pulse_ms_reg    <= pulse_ms_next;
            cooldown_reg    <= cooldown_next;
            thr_reg         <= thr_next;
            spread_reg      <= spread_next;
            window_reg      <= window_next;
            wr_ptr_reg      <= wr_ptr_next;
            hfill_reg       <= hfill_next;
            last_sample_reg <= last_sample_next;
            heater_reg      <= heater_next;
            heat_start_reg  <= heat_start_next;
            settle_reg      <= settle_next;
            last_pulse_reg  <= last_pulse_next;
            ring_ptr_reg    <= ring_ptr_next;
            ring_fill_reg   <= ring_fill_next;
            counts_reg      <= counts_next;
            bidx_reg        <= bidx_next;
            bstart_reg      <= bstart_next;
            bfill_reg       <= bfill_next;
            fault_reg       <= fault_next;
            stuck_reg       <= stuck_next;
            pending_reg     <= pending_next;
            awaiting_reg    <= awaiting_next;
            pdur_reg        <= pdur_next;
            prh_reg         <= prh_next;
            ptemp_reg       <= ptemp_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload and scratch registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        now_reg    <= now_next;
        rvalid_reg <= rvalid_next;
        temp_reg   <= temp_next;
        rh_reg     <= rh_next;
        rd_ptr_reg <= rd_ptr_next;
        ring_reg   <= ring_next;
        ok_reg     <= ok_next;
        mn_reg     <= mn_next;
        mx_reg     <= mx_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        taken_reg  <= taken_next;
        fired_reg  <= fired_next;
        adv_reg    <= adv_next;
        evd_reg    <= evd_next;
        evdur_reg  <= evdur_next;
        evrhb_reg  <= evrhb_next;
        evtb_reg   <= evtb_next;
        evav_reg   <= evav_next;
        evrha_reg  <= evrha_next;
        evta_reg   <= evta_next;
        if (load_out)
        begin
            o_taken_reg  <= taken_reg;
            o_heater_reg <= heater_reg;
            o_stuck_reg  <= stuck_reg;
            o_fault_reg  <= fault_reg;
            o_count_reg  <= acc_wide[2:0];
            o_done_reg   <= evd_reg;
            o_dur_reg    <= evdur_reg;
            o_rhb_reg    <= evrhb_reg;
            o_tb_reg     <= evtb_reg;
            o_av_reg     <= evav_reg;
            o_rha_reg    <= evrha_reg;
            o_ta_reg     <= evta_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign sample_taken       = o_taken_reg;
    assign heater_on          = o_heater_reg;
    assign wet_stuck          = o_stuck_reg;
    assign pulses_in_window   = o_count_reg;
    assign condensation_fault = o_fault_reg;
    assign event_done         = o_done_reg;
    assign event_duration_ms  = o_dur_reg;
    assign event_rh_before    = o_rhb_reg;
    assign event_temp_before  = o_tb_reg;
    assign event_after_valid  = o_av_reg;
    assign event_rh_after     = o_rha_reg;
    assign event_temp_after   = o_ta_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_event_needs_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_done) |-> sample_taken)
        else $error("pulse record without a sample");

    a_heater_has_ring: assert property (@(posedge clk) disable iff (!rst_n)
        heater_reg |-> (ring_fill_reg != '0))
        else $error("heater on with empty pulse ring");

    a_bucket_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(bidx_reg) < 32'(FAULT_BUCKETS)))
        else $error("bucket index out of range");

    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fault_reg |=> fault_reg)
        else $error("condensation fault cleared");

endmodule

// ===== tb/humidity_heater_fault_monitor_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// humidity_heater_fault_monitor_tb
// Self-checking bench: a clocked driver feeds items from a queue in random
// bursts, a behavioral predictor computes each result on every input
// transfer, and a clocked monitor checks every output transfer against it.
// Phases cover several register settings, including the extremes.
// ============================================================================
module humidity_heater_fault_monitor_tb;
    import hhfm_pkg::*;

    localparam int HIST  = 16;
    localparam int STUCK = 8;
    localparam int MAXP  = 4;
    localparam int NBUCK = 2;
    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD  = 600;

    typedef struct packed {
        logic [TIME_W-1:0]        stamp;
        logic                     rd_valid;
        logic signed [TEMP_W-1:0] temp;
        logic [RH_W-1:0]          rh;
    } reading_t;

    typedef struct packed {
        logic                     taken;
        logic                     heat;
        logic                     stuck;
        logic [2:0]               win;
        logic                     fault;
        logic                     done;
        logic [TIME_W-1:0]        dur;
        logic [RH_W-1:0]          rh_b;
        logic signed [TEMP_W-1:0] temp_b;
        logic                     after_ok;
        logic [RH_W-1:0]          rh_a;
        logic signed [TEMP_W-1:0] temp_a;
    } verdict_t;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [TIME_W-1:0] time_ms;
    logic reading_valid;
    logic signed [TEMP_W-1:0] temperature_centi;
    logic [RH_W-1:0] humidity_centi;
    logic sample_taken, heater_on, wet_stuck, condensation_fault, event_done;
    logic [2:0] pulses_in_window;
    logic [TIME_W-1:0] event_duration_ms;
    logic [RH_W-1:0] event_rh_before, event_rh_after;
    logic signed [TEMP_W-1:0] event_temp_before, event_temp_after;
    logic event_after_valid;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    humidity_heater_fault_monitor dut (.*);

    reading_t pending_readings[$];
    verdict_t expected_verdicts[$];
    int mismatches = 0;
    int readings_in = 0;

    // Predictor copy of the registers
    logic        c_present;
    logic [31:0] c_interval, c_pulse, c_cool, c_window;
    logic [13:0] c_thr;
    logic [14:0] c_spread;

    // Predictor copy of the state
    logic        h_valid[HIST], h_heated[HIST], h_settling[HIST];
    int          h_temp[HIST];
    int          h_rh[HIST];
    int          h_ptr, h_fill;
    logic [31:0] last_sample, heat_start, settle_until, last_pulse;
    logic        heat_act, fault_hold, stuck_hold, pulse_open, await_after;
    logic [31:0] pulse_times[MAXP];
    int          pt_ptr, pt_fill;
    int          bk_count[NBUCK];
    int          bk_idx, bk_filled;
    logic [31:0] bk_start, open_dur;
    logic [13:0] open_rh;
    logic [14:0] open_temp;

    function automatic logic [31:0] window_len();
        return (c_window == 0) ? 32'd1 : c_window;
    endfunction

    function automatic logic [2:0] pulses_near(logic [31:0] now);
        int n;
        n = 0;
        for (int i = 0; i < pt_fill && i < MAXP; i++)
            if (32'(now - pulse_times[i]) <= window_len())
                n++;
        return n[2:0];
    endfunction

    function automatic void roll_buckets(logic [31:0] now);
        logic [31:0] w, k, steps;
        logic [63:0] sum;
        int idx;
        w = window_len();
        k = 32'(now - bk_start) / w;
        if (k == 0)
            return;
        bk_start = 32'(bk_start + k * w);
        steps = (k < NBUCK) ? k : NBUCK;
        idx = bk_idx;
        for (int i = 0; i < steps; i++) begin
            idx = (idx + 1) % NBUCK;
            bk_count[idx] = 0;
        end
        bk_idx = (bk_idx + int'(k % NBUCK)) % NBUCK;
        sum = 64'(bk_filled) + 64'(k);
        bk_filled = (sum >= NBUCK) ? NBUCK : int'(sum);
    endfunction

    function automatic logic pulse_allowed(logic [31:0] now);
        if (heat_act)
            return 0;
        if (settle_until != 0 && now < settle_until)
            return 0;
        if (last_pulse != 0 && 32'(now - last_pulse) < c_interval)
            return 0;
        if (pulses_near(now) >= MAXP)
            return 0;
        return 1;
    endfunction

    function automatic void reset_predictor();
        c_present = 0; c_interval = INTERVAL_RST; c_pulse = PULSE_RST;
        c_cool = COOLDOWN_RST; c_thr = RH_THR_RST; c_spread = SPREAD_RST;
        c_window = WINDOW_RST;
        h_ptr = 0; h_fill = 0; last_sample = 0; heat_act = 0; heat_start = 0;
        settle_until = 0; last_pulse = 0; pt_ptr = 0; pt_fill = 0;
        bk_count[0] = 0; bk_count[1] = 0; bk_idx = 0; bk_start = 0; bk_filled = 0;
        fault_hold = 0; stuck_hold = 0; pulse_open = 0; await_after = 0;
        open_dur = 0; open_rh = 0; open_temp = 0;
    endfunction

    // Compute the result of one reading and advance the predicted state
    function automatic verdict_t predict_verdict(reading_t r);
        verdict_t v;
        logic [31:0] now;
        logic ok;
        int mn, mx, idx;
        v = '0;
        now = r.stamp;
        if (c_present) begin
            // heater turn-off
            if (heat_act && 32'(now - heat_start) >= c_pulse) begin
                heat_act = 0;
                settle_until = 32'(now + c_cool);
                if (pulse_open) begin
                    open_dur = 32'(now - heat_start);
                    await_after = 1;
                    pulse_open = 0;
                end
            end
            if (!(last_sample != 0 && 32'(now - last_sample) < c_interval)) begin
                v.taken = 1;
                last_sample = now;
                h_valid[h_ptr] = r.rd_valid;
                h_heated[h_ptr] = heat_act;
                h_settling[h_ptr] = !heat_act && settle_until != 0 && now < settle_until;
                h_temp[h_ptr] = int'(r.temp);
                h_rh[h_ptr] = int'(r.rh);
                h_ptr = (h_ptr + 1) % HIST;
                if (h_fill < HIST)
                    h_fill++;
                // stuck scan over the newest samples
                stuck_hold = 0;
                if (h_fill >= STUCK) begin
                    ok = 1; mn = 0; mx = 0;
                    for (int i = 0; i < STUCK && ok; i++) begin
                        idx = (h_ptr + 2 * HIST - 1 - i) % HIST;
                        if (!h_valid[idx] || h_heated[idx] || h_settling[idx]
                            || h_rh[idx] < int'(c_thr))
                            ok = 0;
                        else if (i == 0) begin
                            mn = h_temp[idx]; mx = h_temp[idx];
                        end
                        else begin
                            if (h_temp[idx] < mn) mn = h_temp[idx];
                            if (h_temp[idx] > mx) mx = h_temp[idx];
                        end
                    end
                    if (ok)
                        stuck_hold = (mx - mn) <= int'(c_spread);
                end
                // fire a pulse
                if (stuck_hold && pulse_allowed(now)) begin
                    pulse_open = 1; await_after = 0;
                    open_rh = r.rh; open_temp = r.temp;
                    heat_act = 1; heat_start = now; last_pulse = now;
                    pulse_times[pt_ptr] = now;
                    pt_ptr = (pt_ptr + 1) % MAXP;
                    if (pt_fill < MAXP)
                        pt_fill++;
                    if (bk_start == 0) begin
                        bk_start = now;
                        if (bk_filled == 0)
                            bk_filled = 1;
                    end
                    roll_buckets(now);
                    if (bk_count[bk_idx] < 65535)
                        bk_count[bk_idx]++;
                end
                // before/after record
                if (await_after) begin
                    v.done = 1; v.dur = open_dur; v.rh_b = open_rh; v.temp_b = open_temp;
                    if (r.rd_valid) begin
                        v.after_ok = 1; v.rh_a = r.rh; v.temp_a = r.temp;
                    end
                    await_after = 0;
                end
                // hourly buckets
                if (bk_start != 0) begin
                    roll_buckets(now);
                    if (bk_filled >= NBUCK && bk_count[bk_idx] > MAXP
                        && bk_count[(bk_idx + NBUCK - 1) % NBUCK] > MAXP)
                        fault_hold = 1;
                end
            end
        end
        v.heat = heat_act;
        v.stuck = stuck_hold;
        v.win = pulses_near(now);
        v.fault = fault_hold;
        return v;
    endfunction

    // Clock and reset
    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        rst_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
    end

    // Driver: bursts of transfers separated by random gaps
    int burst_left, gap_left;
    always @(posedge clk or negedge rst_n) begin
        reading_t nxt;
        if (!rst_n) begin
            in_valid <= 0; time_ms <= '0; reading_valid <= 0;
            temperature_centi <= '0; humidity_centi <= '0;
            burst_left = 1; gap_left = 0;
        end
        else if (!in_valid || !in_stall) begin
            if (in_valid) begin
                expected_verdicts.push_back(predict_verdict(
                    {time_ms, reading_valid, temperature_centi, humidity_centi}));
                readings_in++;
            end
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 0;
            end
            else if (pending_readings.size() > 0) begin
                nxt = pending_readings.pop_front();
                in_valid <= 1;
                time_ms <= nxt.stamp; reading_valid <= nxt.rd_valid;
                temperature_centi <= nxt.temp; humidity_centi <= nxt.rh;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
                end
            end
            else
                in_valid <= 0;
        end
    end

    // Receiver: stall pattern that changes mode, plus one long hold
    int hold_left, mode_left, stall_mode;
    logic hold_done;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 0; hold_left = 0; mode_left = 0; stall_mode = 0; hold_done = 0;
        end
        else if (hold_left > 0) begin
            out_stall <= 1;
            hold_left--;
        end
        else if (!hold_done && readings_in >= 400) begin
            hold_done = 1;
            hold_left = LONG_HOLD;
            out_stall <= 1;
        end
        else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            else
                mode_left--;
            case (stall_mode)
                0: out_stall <= 0;
                1: out_stall <= ($urandom_range(0, 99) < 35);
                default: out_stall <= (mode_left % 8 < 3);
            endcase
        end
    end

    // Monitor: compare each output transfer with the oldest expectation
    always @(posedge clk) begin
        verdict_t got, want;
        if (rst_n && out_valid && !out_stall) begin
            got = {sample_taken, heater_on, wet_stuck, pulses_in_window,
                   condensation_fault, event_done, event_duration_ms, event_rh_before,
                   event_temp_before, event_after_valid, event_rh_after, event_temp_after};
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end
            else begin
                want = expected_verdicts.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, actual %p", want, got);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    int idle_cycles = 0;
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stimulus helpers
    logic [31:0] clock_ms;

    task automatic push_reading(logic [31:0] t, logic ok, int temp, int rh);
        reading_t r;
        r.stamp = t; r.rd_valid = ok; r.temp = temp[14:0]; r.rh = rh[13:0];
        pending_readings.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_readings.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] d);
        @(posedge clk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
        @(posedge clk);
        cfg_we <= 0;
        case (idx)
            REG_SENSOR_PRESENT:  c_present = d[0];
            REG_SAMPLE_INTERVAL: c_interval = d;
            REG_HEATER_PULSE:    c_pulse = d;
            REG_COOLDOWN:        c_cool = d;
            REG_RH_THRESHOLD:    c_thr = d[13:0];
            REG_TEMP_SPREAD:     c_spread = d[14:0];
            default:             c_window = d;
        endcase
    endtask

    task automatic set_timing(logic [31:0] ivl, logic [31:0] pls, logic [31:0] cool,
                              logic [31:0] thr, logic [31:0] spr, logic [31:0] win);
        write_reg(REG_SAMPLE_INTERVAL, ivl);
        write_reg(REG_HEATER_PULSE, pls);
        write_reg(REG_COOLDOWN, cool);
        write_reg(REG_RH_THRESHOLD, thr);
        write_reg(REG_TEMP_SPREAD, spr);
        write_reg(REG_PULSE_WINDOW, win);
    endtask

    // Random readings: mostly wet runs that can trip the heater, some noise
    task automatic queue_random(int count);
        int pick, base_t, spr, rh_lo;
        logic [31:0] step;
        base_t = $urandom_range(0, 8000) - 2000;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            step = c_interval + ((c_interval > 64) ? $urandom_range(0, c_interval / 4)
                                                   : $urandom_range(0, 3));
            if (pick < 10)
                step = (c_interval > 1) ? $urandom_range(0, c_interval - 1) : 0;
            else if (pick >= 96)
                step = $urandom;
            clock_ms = 32'(clock_ms + step);
            if ($urandom_range(0, 39) == 0)
                base_t = $urandom_range(0, 16500) - 4000;
            spr = (c_spread > 40) ? 40 : int'(c_spread);
            rh_lo = (c_thr > 10000) ? 10000 : int'(c_thr);
            if (pick < 80)
                push_reading(clock_ms, 1, base_t + $urandom_range(0, spr),
                             $urandom_range(rh_lo, 10000));
            else if (pick < 88)
                push_reading(clock_ms, $urandom_range(0, 1),
                             $urandom_range(0, 16500) - 4000, $urandom_range(0, 10000));
            else
                push_reading(clock_ms, $urandom_range(0, 1), $urandom, $urandom);
        end
    endtask

    initial begin
        cfg_we = 0; cfg_index = '0; cfg_data = '0;
        reset_predictor();
        clock_ms = 0;
        wait (rst_n === 1'b1);

        // sensor absent after reset: items are ignored
        push_reading(0, 1, 2500, 9800);
        push_reading(5000, 1, 2500, 9800);
        push_reading(32'hFFFF_FFFF, 0, -4000, 0);
        wait_drained();

        // defaults, directed: zero stamp, a wet run, pulse, record with bad after
        write_reg(REG_SENSOR_PRESENT, 1);
        push_reading(0, 1, 2500, 9600);
        push_reading(1, 1, 2500, 9600);
        for (int i = 1; i <= 8; i++)
            push_reading(i * 2000, 1, 2500 + i % 2, 9600 + i);
        push_reading(17000, 1, 2500, 9600);
        push_reading(19000, 0, 12500, 10000);
        push_reading(21000, 1, -4000, 0);
        push_reading(23000, 1, 12500, 10000);
        push_reading(25000, 0, 0, 0);
        push_reading(27000, 1, -1, 16383);
        clock_ms = 27000;
        wait_drained();
        queue_random(130);
        wait_drained();

        set_timing(10, 15, 20, 9000, 50, 200);
        queue_random(260);
        wait_drained();

        set_timing(1, 1, 0, 0, 0, 1);
        queue_random(150);
        wait_drained();

        set_timing(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10000, 16500, 32'hFFFF_FFFF);
        queue_random(100);
        wait_drained();

        set_timing(32'hFFFF_FFFF, 1000, 10000, 16383, 32767, 1000);
        queue_random(50);
        wait_drained();

        // counter wrap with a short window
        set_timing(20, 30, 0, 9500, 20, 150);
        clock_ms = 32'hFFFF_F000;
        queue_random(270);
        wait_drained();

        write_reg(REG_SENSOR_PRESENT, 0);
        queue_random(40);
        wait_drained();

        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== humidity_heater_fault_monitor.f =====
hw/rtl/hhfm_pkg.sv
hw/rtl/hhfm_ram.sv
hw/rtl/hhfm_div.sv
hw/rtl/humidity_heater_fault_monitor.sv
tb/humidity_heater_fault_monitor_tb.sv
